// ----- hw/rtl/uap_pkg.sv -----
// Shared types and constants for the URI authority parser.
package uap_pkg;

    localparam int MAX_LEN_DEFAULT = 1024;
    localparam int OFF_W           = 10;
    localparam int PORT_W          = 16;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SYNTAX = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;
    localparam logic [1:0] ST_LONG   = 2'd3;

    localparam logic [PORT_W-1:0] PORT_SAT = 16'hFFFF;

    typedef enum logic [6:0] {
        PH_SLASH1  = 7'b0000001,
        PH_SLASH2  = 7'b0000010,
        PH_HOST    = 7'b0000100,
        PH_BRACKET = 7'b0001000,
        PH_AFTER   = 7'b0010000,
        PH_PORT    = 7'b0100000,
        PH_PATH    = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              userinfo_present;
        logic [OFF_W-1:0]  userinfo_length;
        logic [OFF_W-1:0]  host_offset;
        logic [OFF_W-1:0]  host_length;
        logic              port_present;
        logic [PORT_W-1:0] port_number;
        logic              path_present;
        logic [OFF_W-1:0]  path_offset;
        logic [OFF_W-1:0]  path_length;
    } result_t;

endpackage

// ----- hw/rtl/uri_authority_parser.sv -----
// URI authority parser: byte-stream splitter of userinfo, host, port and path.
// Throughput: one byte beat per cycle; a last byte waits in the input register
// while an earlier result beat is stalled.
// Result path: a last byte is taken into the input register, then parse logic
// loads its result beat into the result register.
// Reset: rst_n clears both pipeline valids and the parse state at once.
module uri_authority_parser #(
    parameter int MAX_LEN = uap_pkg::MAX_LEN_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  uap_pkg::in_beat_t byte_data,
    output logic              result_valid,
    input  logic              result_ready,
    output uap_pkg::result_t  result_data
);

    localparam int POS_W = $clog2(MAX_LEN + 1);
    localparam int OFF_W = uap_pkg::OFF_W;

    function automatic logic is_unreserved(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || c == 8'h2D || c == 8'h2E ||
               c == 8'h5F || c == 8'h7E;
    endfunction

    function automatic logic [OFF_W-1:0] to_off(input logic [POS_W-1:0] x);
        logic [POS_W+OFF_W-1:0] wide;
        wide = {{OFF_W{1'b0}}, x};
        return wide[OFF_W-1:0];
    endfunction

    logic              s1_valid_reg;
    uap_pkg::in_beat_t s1_beat_reg;
    logic              out_valid_reg;
    uap_pkg::result_t  out_data_reg;
    uap_pkg::result_t  out_data_next;
    logic              s1_consume;

    uap_pkg::phase_t          phase_reg, phase_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [OFF_W-1:0]         ui_len_reg, ui_len_next;
    logic                     ui_flag_reg, ui_flag_next;
    logic [OFF_W-1:0]         host_begin_reg, host_begin_next;
    logic [POS_W-1:0]         host_len_reg, host_len_next;
    logic                     port_flag_reg, port_flag_next;
    logic [uap_pkg::PORT_W-1:0] port_acc_reg, port_acc_next;
    logic                     path_flag_reg, path_flag_next;
    logic [OFF_W-1:0]         path_begin_reg, path_begin_next;
    logic [1:0]               err_reg, err_next;

    logic [7:0]       c;
    logic [POS_W-1:0] pos_inc;
    logic [19:0]      port_mul;
    logic [1:0]       st;

    assign s1_consume   = s1_valid_reg &&
                          (!s1_beat_reg.last_byte || !out_valid_reg || result_ready);
    assign byte_ready   = !s1_valid_reg || s1_consume;
    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    assign c        = s1_beat_reg.char_byte;
    assign pos_inc  = pos_reg + 1'b1;
    assign port_mul = {1'b0, port_acc_reg, 3'b000} + {3'b000, port_acc_reg, 1'b0}
                      + {16'd0, c[3:0] - 4'd0};

    always_comb
    begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        ui_len_next     = ui_len_reg;
        ui_flag_next    = ui_flag_reg;
        host_begin_next = host_begin_reg;
        host_len_next   = host_len_reg;
        port_flag_next  = port_flag_reg;
        port_acc_next   = port_acc_reg;
        path_flag_next  = path_flag_reg;
        path_begin_next = path_begin_reg;
        err_next        = err_reg;

        if (err_reg == uap_pkg::ST_OK)
        begin
            if (pos_reg >= POS_W'(MAX_LEN))
            begin
                err_next = uap_pkg::ST_LONG;
            end
            else
            begin
                pos_next = pos_inc;
                case (phase_reg)
                    uap_pkg::PH_SLASH1:
                    begin
                        if (c == 8'h2F) phase_next = uap_pkg::PH_SLASH2;
                        else            err_next   = uap_pkg::ST_SYNTAX;
                    end
                    uap_pkg::PH_SLASH2:
                    begin
                        if (c == 8'h2F) phase_next = uap_pkg::PH_HOST;
                        else            err_next   = uap_pkg::ST_SYNTAX;
                    end
                    uap_pkg::PH_HOST:
                    begin
                        if (is_unreserved(c))
                        begin
                            host_len_next = host_len_reg + 1'b1;
                        end
                        else if (c == 8'h40 && !ui_flag_reg)
                        begin
                            ui_flag_next    = 1'b1;
                            ui_len_next     = to_off(host_len_reg);
                            host_begin_next = to_off(pos_inc);
                            host_len_next   = '0;
                        end
                        else if (c == 8'h5B && host_len_reg == '0)
                        begin
                            host_begin_next = to_off(pos_reg);
                            host_len_next   = POS_W'(1);
                            phase_next      = uap_pkg::PH_BRACKET;
                        end
                        else if (c == 8'h3A)
                        begin
                            port_flag_next = 1'b1;
                            phase_next     = uap_pkg::PH_PORT;
                        end
                        else if (c == 8'h2F)
                        begin
                            path_flag_next  = 1'b1;
                            path_begin_next = to_off(pos_inc);
                            phase_next      = uap_pkg::PH_PATH;
                        end
                        else
                        begin
                            err_next = uap_pkg::ST_SYNTAX;
                        end
                    end
                    uap_pkg::PH_BRACKET:
                    begin
                        if (c == 8'h5D)      phase_next    = uap_pkg::PH_AFTER;
                        else if (c == 8'h00) err_next      = uap_pkg::ST_SYNTAX;
                        else                 host_len_next = host_len_reg + 1'b1;
                    end
                    uap_pkg::PH_AFTER:
                    begin
                        if (c == 8'h3A)
                        begin
                            port_flag_next = 1'b1;
                            phase_next     = uap_pkg::PH_PORT;
                        end
                        else if (c == 8'h2F)
                        begin
                            path_flag_next  = 1'b1;
                            path_begin_next = to_off(pos_inc);
                            phase_next      = uap_pkg::PH_PATH;
                        end
                        else
                        begin
                            err_next = uap_pkg::ST_SYNTAX;
                        end
                    end
                    uap_pkg::PH_PORT:
                    begin
                        if (c >= 8'h30 && c <= 8'h39)
                        begin
                            if (port_mul > {4'd0, uap_pkg::PORT_SAT})
                                port_acc_next = uap_pkg::PORT_SAT;
                            else
                                port_acc_next = port_mul[15:0];
                        end
                        else if (c == 8'h2F)
                        begin
                            path_flag_next  = 1'b1;
                            path_begin_next = to_off(pos_inc);
                            phase_next      = uap_pkg::PH_PATH;
                        end
                        else
                        begin
                            err_next = uap_pkg::ST_SYNTAX;
                        end
                    end
                    uap_pkg::PH_PATH:
                    begin
                        if (!is_unreserved(c)) err_next = uap_pkg::ST_SYNTAX;
                    end
                    default:
                    begin
                        err_next = uap_pkg::ST_SYNTAX;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        st = err_next;
        if (err_next == uap_pkg::ST_OK)
        begin
            if (phase_next == uap_pkg::PH_SLASH1 || phase_next == uap_pkg::PH_SLASH2 ||
                phase_next == uap_pkg::PH_BRACKET)
                st = uap_pkg::ST_SYNTAX;
            else if (port_flag_next && port_acc_next == uap_pkg::PORT_SAT)
                st = uap_pkg::ST_RANGE;
        end

        out_data_next        = '0;
        out_data_next.status = st;
        if (st == uap_pkg::ST_OK)
        begin
            out_data_next.userinfo_present = ui_flag_next;
            out_data_next.userinfo_length  = ui_len_next;
            out_data_next.host_offset      = host_begin_next;
            out_data_next.host_length      = to_off(host_len_next);
            out_data_next.port_present     = port_flag_next;
            out_data_next.port_number      = port_acc_next;
            if (path_flag_next)
            begin
                out_data_next.path_present = 1'b1;
                out_data_next.path_offset  = path_begin_next;
                out_data_next.path_length  = to_off(pos_next) - path_begin_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= uap_pkg::PH_SLASH1;
            pos_reg        <= '0;
            ui_len_reg     <= '0;
            ui_flag_reg    <= 1'b0;
            host_begin_reg <= OFF_W'(2);
            host_len_reg   <= '0;
            port_flag_reg  <= 1'b0;
            port_acc_reg   <= '0;
            path_flag_reg  <= 1'b0;
            path_begin_reg <= '0;
            err_reg        <= uap_pkg::ST_OK;
        end
        else
        begin
            if (byte_ready)
                s1_valid_reg <= byte_valid;

            if (s1_consume && s1_beat_reg.last_byte)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;

            if (s1_consume)
            begin
                if (s1_beat_reg.last_byte)
                begin
                    phase_reg      <= uap_pkg::PH_SLASH1;
                    pos_reg        <= '0;
                    ui_len_reg     <= '0;
                    ui_flag_reg    <= 1'b0;
                    host_begin_reg <= OFF_W'(2);
                    host_len_reg   <= '0;
                    port_flag_reg  <= 1'b0;
                    port_acc_reg   <= '0;
                    path_flag_reg  <= 1'b0;
                    path_begin_reg <= '0;
                    err_reg        <= uap_pkg::ST_OK;
                end
                else
                begin
                    phase_reg      <= phase_next;
                    pos_reg        <= pos_next;
                    ui_len_reg     <= ui_len_next;
                    ui_flag_reg    <= ui_flag_next;
                    host_begin_reg <= host_begin_next;
                    host_len_reg   <= host_len_next;
                    port_flag_reg  <= port_flag_next;
                    port_acc_reg   <= port_acc_next;
                    path_flag_reg  <= path_flag_next;
                    path_begin_reg <= path_begin_next;
                    err_reg        <= err_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
            s1_beat_reg <= byte_data;
        if (s1_consume && s1_beat_reg.last_byte)
            out_data_reg <= out_data_next;
    end

endmodule

// ----- hw/rtl/uap_checker.sv -----
// Port-level checks for the URI authority parser, bound to the top level.
module uap_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_ready,
    input uap_pkg::result_t  result_data
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result beat dropped or changed while stalled");

    a_error_clears: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.status != uap_pkg::ST_OK |->
            !result_data.userinfo_present && result_data.userinfo_length == '0 &&
            result_data.host_offset == '0 && result_data.host_length == '0 &&
            !result_data.port_present && result_data.port_number == '0 &&
            !result_data.path_present && result_data.path_offset == '0 &&
            result_data.path_length == '0)
        else $error("error result carries nonzero fields");

    a_no_path: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_data.path_present |->
            result_data.path_offset == '0 && result_data.path_length == '0)
        else $error("path fields set without a path");

    a_no_port: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_data.port_present |-> result_data.port_number == '0)
        else $error("port number set without a port");

    a_port_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.status == uap_pkg::ST_OK |->
            result_data.port_number != uap_pkg::PORT_SAT)
        else $error("saturated port reported as ok");

endmodule

bind uri_authority_parser uap_checker u_uap_checker (.*);
